// File: hw/rtl/hlfd_pkg.sv
// Shared types and constants for the header/length frame deframer.
`timescale 1ns / 1ps

package hlfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] RESET_FIRST_HEADER  = 8'h5A;
  localparam logic [BYTE_W-1:0] RESET_SECOND_HEADER = 8'hA5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 1'b1;

  // Payload positions that are kept
  localparam logic [BYTE_W-1:0] POS_COMMAND  = 8'd0;
  localparam logic [BYTE_W-1:0] POS_ADDR_HI  = 8'd1;
  localparam logic [BYTE_W-1:0] POS_ADDR_LO  = 8'd2;
  localparam logic [BYTE_W-1:0] POS_COUNT    = 8'd3;
  localparam logic [BYTE_W-1:0] POS_VALUE_HI = 8'd4;
  localparam logic [BYTE_W-1:0] POS_VALUE_LO = 8'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LENGTH,
    ST_PAYLOAD
  } state_t;

endpackage

// File: hw/rtl/header_length_frame_deframer.sv
// Top level of the two-byte-header, length-prefixed frame deframer.
`timescale 1ns / 1ps

// Takes one received byte per cycle and finds frames of the form
// second_header, length, payload. A first_header byte aborts any frame in
// progress; a second_header byte restarts length capture. Payload bytes 0..5
// give command, address (high first), word count and value (high first);
// positions not received read as zero. A result is presented in the cycle after
// the last payload byte (or the length byte when the length is zero) is
// taken. Throughput is one byte per cycle: all per-byte work is a single
// state update into a registered result stage. The input stalls only while
// a result sits in the output register and is not being taken.
module header_length_frame_deframer (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_we,
  input  logic [hlfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hlfd_pkg::BYTE_W-1:0]  cfg_data,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hlfd_pkg::BYTE_W-1:0]  in_rx_byte,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hlfd_pkg::BYTE_W-1:0]  out_command,
  output logic [hlfd_pkg::HALF_W-1:0]  out_address,
  output logic [hlfd_pkg::BYTE_W-1:0]  out_word_count,
  output logic [hlfd_pkg::HALF_W-1:0]  out_value,
  output logic [hlfd_pkg::BYTE_W-1:0]  out_frame_length
);

  logic [hlfd_pkg::BYTE_W-1:0] first_hdr_r, second_hdr_r;

  hlfd_pkg::state_t state_r, state_nxt;

  logic [hlfd_pkg::BYTE_W-1:0] exp_len_r, exp_len_nxt;
  logic [hlfd_pkg::BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [hlfd_pkg::BYTE_W-1:0] cnt_inc;
  logic [hlfd_pkg::BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [hlfd_pkg::HALF_W-1:0] addr_r, addr_nxt;
  logic [hlfd_pkg::BYTE_W-1:0] wcnt_r, wcnt_nxt;
  logic [hlfd_pkg::HALF_W-1:0] val_r, val_nxt;

  logic                        out_valid_r;
  logic [hlfd_pkg::BYTE_W-1:0] out_cmd_r;
  logic [hlfd_pkg::HALF_W-1:0] out_addr_r;
  logic [hlfd_pkg::BYTE_W-1:0] out_wcnt_r;
  logic [hlfd_pkg::HALF_W-1:0] out_val_r;
  logic [hlfd_pkg::BYTE_W-1:0] out_len_r;

  logic in_acc;
  logic is_first, is_second;
  logic emit;
  logic last_byte;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign is_first  = (in_rx_byte == first_hdr_r);
  assign is_second = (in_rx_byte == second_hdr_r);
  assign cnt_inc   = cnt_r + 8'd1;
  assign last_byte = (cnt_inc >= exp_len_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_hdr_r  <= hlfd_pkg::RESET_FIRST_HEADER;
      second_hdr_r <= hlfd_pkg::RESET_SECOND_HEADER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hlfd_pkg::CFG_FIRST_HEADER:  first_hdr_r  <= cfg_data;
        hlfd_pkg::CFG_SECOND_HEADER: second_hdr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state; header bytes win over everything else
  always_comb begin
    state_nxt = state_r;
    if (in_acc) begin
      if (is_first) begin
        state_nxt = hlfd_pkg::ST_IDLE;
      end else if (is_second) begin
        state_nxt = hlfd_pkg::ST_LENGTH;
      end else begin
        unique case (state_r)
          hlfd_pkg::ST_LENGTH: begin
            state_nxt = (in_rx_byte == '0) ? hlfd_pkg::ST_IDLE : hlfd_pkg::ST_PAYLOAD;
          end
          hlfd_pkg::ST_PAYLOAD: begin
            if (last_byte) state_nxt = hlfd_pkg::ST_IDLE;
          end
          default: state_nxt = state_r;
        endcase
      end
    end
  end

  // Frame datapath and result strobe
  always_comb begin
    exp_len_nxt = exp_len_r;
    cnt_nxt     = cnt_r;
    cmd_nxt     = cmd_r;
    addr_nxt    = addr_r;
    wcnt_nxt    = wcnt_r;
    val_nxt     = val_r;
    emit        = 1'b0;
    if (in_acc && !is_first && !is_second) begin
      unique case (state_r)
        hlfd_pkg::ST_LENGTH: begin
          // clear the payload fields so short frames read zero
          exp_len_nxt = in_rx_byte;
          cnt_nxt     = '0;
          cmd_nxt     = '0;
          addr_nxt    = '0;
          wcnt_nxt    = '0;
          val_nxt     = '0;
          emit        = (in_rx_byte == '0);
        end
        hlfd_pkg::ST_PAYLOAD: begin
          case (cnt_r)
            hlfd_pkg::POS_COMMAND:  cmd_nxt = in_rx_byte;
            hlfd_pkg::POS_ADDR_HI:  addr_nxt = {in_rx_byte, addr_r[7:0]};
            hlfd_pkg::POS_ADDR_LO:  addr_nxt = {addr_r[15:8], in_rx_byte};
            hlfd_pkg::POS_COUNT:    wcnt_nxt = in_rx_byte;
            hlfd_pkg::POS_VALUE_HI: val_nxt = {in_rx_byte, val_r[7:0]};
            hlfd_pkg::POS_VALUE_LO: val_nxt = {val_r[15:8], in_rx_byte};
            default: ;
          endcase
          cnt_nxt = cnt_inc;
          emit    = last_byte;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hlfd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame fields are always rewritten at the length byte before use
  always_ff @(posedge clk) begin
    exp_len_r <= exp_len_nxt;
    cnt_r     <= cnt_nxt;
    cmd_r     <= cmd_nxt;
    addr_r    <= addr_nxt;
    wcnt_r    <= wcnt_nxt;
    val_r     <= val_nxt;
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cmd_r  <= cmd_nxt;
      out_addr_r <= addr_nxt;
      out_wcnt_r <= wcnt_nxt;
      out_val_r  <= val_nxt;
      out_len_r  <= exp_len_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_command      = out_cmd_r;
  assign out_address      = out_addr_r;
  assign out_word_count   = out_wcnt_r;
  assign out_value        = out_val_r;
  assign out_frame_length = out_len_r;

`ifndef SYNTH
  a_payload_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hlfd_pkg::ST_PAYLOAD |-> (cnt_r < exp_len_r))
    else $error("payload count reached frame length while collecting");

  a_first_header_aborts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_rx_byte == first_hdr_r) |=> state_r == hlfd_pkg::ST_IDLE && !$rose(out_valid))
    else $error("first header did not abort the frame");

  a_second_header_arms: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_rx_byte != first_hdr_r) && (in_rx_byte == second_hdr_r)
    |=> state_r == hlfd_pkg::ST_LENGTH)
    else $error("second header did not arm length capture");

  a_empty_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_len_r == '0) |-> (out_cmd_r == '0) && (out_addr_r == '0)
      && (out_wcnt_r == '0) && (out_val_r == '0))
    else $error("zero-length frame carries payload");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !emit)
    else $error("result overwritten before it was taken");
`endif

endmodule
